/* rtl/mabrb_pkg.sv */
// Package for the message-atomic byte ring buffer.
// Holds the opcode, status and direction codes, field widths and the result struct.
// No dependencies.
package mabrb_pkg;

    // Default store capacity in bytes
    localparam int CAPACITY_DEF = 4096;
    // Register value of buffer_size after reset
    localparam int BUF_SIZE_RST = 4096;

    // Field widths
    localparam int SIZE_W   = 13;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int OPC_W    = 3;
    localparam int STAT_W   = 3;
    localparam int DIR_W    = 2;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 48;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_WR_REQ  = 3'd0;
    localparam logic [OPC_W-1:0] OP_WR_BYTE = 3'd1;
    localparam logic [OPC_W-1:0] OP_RD_REQ  = 3'd2;
    localparam logic [OPC_W-1:0] OP_RD_BYTE = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR   = 3'd4;
    localparam logic [OPC_W-1:0] OP_INQUIRE = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID    = 3'd1;
    localparam logic [STAT_W-1:0] ST_WOULDBLOCK = 3'd2;
    localparam logic [STAT_W-1:0] ST_WAIT       = 3'd3;
    localparam logic [STAT_W-1:0] ST_SEQ        = 3'd4;

    // Transfer direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_WRITE = 2'd1;
    localparam logic [DIR_W-1:0] DIR_READ  = 2'd2;

    // Result of one transaction, read_data excluded (it comes from the RAM)
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] granted;
        logic              done;
        logic              wake;
        logic [SIZE_W-1:0] fill;
        logic [SIZE_W-1:0] free;
    } result_t;

endpackage

/* rtl/mabrb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mabrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mabrb_core.sv */
// Ring buffer control: offsets, fill count, pending transfer and the request decisions.
// Depends on mabrb_pkg; drives the store RAM ports from the top level.
module mabrb_core
    import mabrb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [SIZE_W-1:0]           cfg_data,
    input  logic                        step,
    input  logic [OPC_W-1:0]            opcode,
    input  logic [LEN_W-1:0]            length,
    input  logic [BYTE_W-1:0]           data_byte,
    input  logic                        nonblocking,
    input  logic                        peers_waiting,
    input  logic [SIZE_W-1:0]           lead_waiter_size,
    output result_t                     res,
    output logic                        fetch,
    output logic                        mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [BYTE_W-1:0]           mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr
);

    localparam int AW = $clog2(CAPACITY);
    // Width that holds both an incremented offset and a size
    localparam int CW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam int SIZE_RST = (CAPACITY < BUF_SIZE_RST) ? CAPACITY : BUF_SIZE_RST;

    logic [SIZE_W-1:0] size_reg,  size_next;
    logic [AW-1:0]     rd_off_reg, rd_off_next;
    logic [AW-1:0]     wr_off_reg, wr_off_next;
    logic [SIZE_W-1:0] fill_reg,  fill_next;
    logic [SIZE_W-1:0] rem_reg,   rem_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [DIR_W-1:0]  dir_reg,   dir_next;

    logic [SIZE_W-1:0] fill_inc, fill_dec, rem_dec, eff_size;
    logic [CW-1:0]     rd_adv, wr_adv;
    logic              len_zero, len_over, no_room;

    // Clamp of a written size to 1..CAPACITY
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(cfg_data) > 32'(CAPACITY))
        begin
            eff_size = SIZE_W'(CAPACITY);
        end
        else
        begin
            eff_size = cfg_data;
        end
    end

    // Shared arithmetic
    assign fill_inc = fill_reg + SIZE_W'(1);
    assign fill_dec = fill_reg - SIZE_W'(1);
    assign rem_dec  = rem_reg - SIZE_W'(1);
    assign rd_adv   = CW'(rd_off_reg) + CW'(1);
    assign wr_adv   = CW'(wr_off_reg) + CW'(1);
    assign len_zero = (length == '0);
    assign len_over = (length > LEN_W'(size_reg));
    assign no_room  = ((17'(fill_reg) + 17'(length)) > 17'(size_reg));

    // Per-transaction decision and next state
    always_comb
    begin
        size_next   = size_reg;
        rd_off_next = rd_off_reg;
        wr_off_next = wr_off_reg;
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        total_next  = total_reg;
        dir_next    = dir_reg;
        res.status  = ST_OK;
        res.granted = '0;
        res.done    = 1'b0;
        res.wake    = 1'b0;
        fetch       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        unique case (opcode)
            OP_WR_REQ:
            begin
                priority if (dir_reg != DIR_NONE)
                begin
                    res.status = ST_SEQ;
                end
                else if (len_zero)
                begin
                    res.status = ST_OK;
                end
                else if (len_over)
                begin
                    res.status = ST_INVALID;
                end
                else if (no_room)
                begin
                    if (nonblocking)
                    begin
                        res.status = ST_WOULDBLOCK;
                    end
                    else
                    begin
                        res.status = ST_WAIT;
                        res.wake   = (fill_reg != '0) && peers_waiting;
                    end
                end
                else
                begin
                    res.granted = SIZE_W'(length);
                    dir_next    = DIR_WRITE;
                    total_next  = SIZE_W'(length);
                    rem_next    = SIZE_W'(length);
                end
            end
            OP_WR_BYTE:
            begin
                if (dir_reg != DIR_WRITE || rem_reg == '0 || fill_reg >= size_reg)
                begin
                    res.status = ST_SEQ;
                end
                else
                begin
                    mem_we      = 1'b1;
                    wr_off_next = (wr_adv >= CW'(size_reg)) ? '0 : AW'(wr_adv);
                    fill_next   = fill_inc;
                    rem_next    = rem_dec;
                    res.granted = total_reg;
                    if (rem_reg == SIZE_W'(1))
                    begin
                        res.done   = 1'b1;
                        res.wake   = peers_waiting && (lead_waiter_size <= fill_inc);
                        dir_next   = DIR_NONE;
                        total_next = '0;
                    end
                end
            end
            OP_RD_REQ:
            begin
                priority if (dir_reg != DIR_NONE)
                begin
                    res.status = ST_SEQ;
                end
                else if (len_zero)
                begin
                    res.status = ST_OK;
                end
                else if (len_over)
                begin
                    res.status = ST_INVALID;
                end
                else if (LEN_W'(fill_reg) >= length)
                begin
                    res.granted = SIZE_W'(length);
                    dir_next    = DIR_READ;
                    total_next  = SIZE_W'(length);
                    rem_next    = SIZE_W'(length);
                end
                else if (nonblocking)
                begin
                    res.status = ST_WOULDBLOCK;
                end
                else if (fill_reg != '0 && peers_waiting)
                begin
                    // short read of the whole fill
                    res.granted = fill_reg;
                    dir_next    = DIR_READ;
                    total_next  = fill_reg;
                    rem_next    = fill_reg;
                end
                else
                begin
                    res.status = ST_WAIT;
                end
            end
            OP_RD_BYTE:
            begin
                if (dir_reg != DIR_READ || rem_reg == '0 || fill_reg == '0)
                begin
                    res.status = ST_SEQ;
                end
                else
                begin
                    mem_re      = 1'b1;
                    fetch       = 1'b1;
                    rd_off_next = (rd_adv >= CW'(size_reg)) ? '0 : AW'(rd_adv);
                    fill_next   = fill_dec;
                    rem_next    = rem_dec;
                    res.granted = total_reg;
                    if (rem_reg == SIZE_W'(1))
                    begin
                        res.done   = 1'b1;
                        res.wake   = peers_waiting &&
                                     ((14'(lead_waiter_size) + 14'(fill_dec)) <= 14'(size_reg));
                        dir_next   = DIR_NONE;
                        total_next = '0;
                    end
                end
            end
            OP_CLEAR:
            begin
                rd_off_next = '0;
                wr_off_next = '0;
                fill_next   = '0;
                rem_next    = '0;
                total_next  = '0;
                dir_next    = DIR_NONE;
                res.wake    = peers_waiting;
            end
            OP_INQUIRE:
            begin
                res.status = ST_OK;
            end
            default:
            begin
                res.status = ST_SEQ;
            end
        endcase

        res.fill = fill_next;
        res.free = size_reg - fill_next;

        // A size write empties the buffer and aborts any transfer
        if (cfg_we)
        begin
            size_next   = eff_size;
            rd_off_next = '0;
            wr_off_next = '0;
            fill_next   = '0;
            rem_next    = '0;
            total_next  = '0;
            dir_next    = DIR_NONE;
        end
    end

    // Store ports
    assign mem_waddr = wr_off_reg;
    assign mem_wdata = data_byte;
    assign mem_raddr = rd_off_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_W'(SIZE_RST);
            rd_off_reg <= '0;
            wr_off_reg <= '0;
            fill_reg   <= '0;
            rem_reg    <= '0;
            total_reg  <= '0;
            dir_reg    <= DIR_NONE;
        end
        else if (step || cfg_we)
        begin
            size_reg   <= size_next;
            rd_off_reg <= rd_off_next;
            wr_off_reg <= wr_off_next;
            fill_reg   <= fill_next;
            rem_reg    <= rem_next;
            total_reg  <= total_next;
            dir_reg    <= dir_next;
        end
    end

endmodule

/* rtl/message_atomic_byte_ring_buffer.sv */
// Top level of the message-atomic byte ring buffer: handshake, output register, store RAM.
// Depends on mabrb_pkg, mabrb_ram and mabrb_core.
//
// Usage
//   s_* carries request transactions: s_tuser is the opcode, s_tdata the operands.
//   m_* returns exactly one result per request: m_tuser is the status, m_tlast
//   marks the last byte of a message transfer, m_tdata the counts and data.
//   cfg_we/cfg_data write buffer_size (clamped to 1..CAPACITY); this empties the
//   buffer and aborts any transfer. Write it only while the block is idle.
// Results and flow
//   A result is registered and appears in the cycle after its request is accepted;
//   a read-byte result passes the registered store RAM read and ST_FETCH first. One
//   request per cycle is taken while the output is not stalled, except after a read
//   byte, which holds the input while the RAM read completes.
// Reset
//   rst_n clears offsets, fill and the pending transfer; buffer_size returns to
//   4096 (or CAPACITY if smaller). The store itself is not cleared; no clearing pass.
// Stall
//   While m_tready is low the result is held and at most one request is taken,
//   and only while the output register is empty.
module message_atomic_byte_ring_buffer
    import mabrb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    // opcode[2:0]
    input  logic [OPC_W-1:0]   s_tuser,
    // length[15:0], data_byte[23:16], nonblocking[24], peers_waiting[25],
    // lead_waiter_size[38:26], zero pad[39]
    input  logic [IN_DW-1:0]   s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status[2:0]
    output logic [STAT_W-1:0]  m_tuser,
    // transfer_done
    output logic               m_tlast,
    // granted_length[12:0], read_data[20:13], wake_peers[21], fill_level[34:22],
    // free_space[47:35]
    output logic [OUT_DW-1:0]  m_tdata
);

    localparam int AW = $clog2(CAPACITY);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic              state_reg, state_next;
    logic              mvalid_reg;
    logic [STAT_W-1:0] status_reg;
    logic              last_reg;
    logic [SIZE_W-1:0] granted_reg, fill_reg, free_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              wake_reg;

    logic              step, fetch;
    result_t           res;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata;

    // Input handshake: free output slot and no RAM read in flight
    assign s_tready = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign step     = s_tvalid && s_tready;

    mabrb_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .step             (step),
        .opcode           (s_tuser),
        .length           (s_tdata[15:0]),
        .data_byte        (s_tdata[23:16]),
        .nonblocking      (s_tdata[24]),
        .peers_waiting    (s_tdata[25]),
        .lead_waiter_size (s_tdata[38:26]),
        .res              (res),
        .fetch            (fetch),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_re           (mem_re),
        .mem_raddr        (mem_raddr)
    );

    mabrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we && step),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re && step),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer: a read byte waits in ST_FETCH for the RAM data
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step && fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FETCH)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (step)
            begin
                mvalid_reg <= !fetch;
            end
            else if (m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg  <= res.status;
            granted_reg <= res.granted;
            last_reg    <= res.done;
            wake_reg    <= res.wake;
            fill_reg    <= res.fill;
            free_reg    <= res.free;
            rdata_reg   <= '0;
        end
        else if (state_reg == ST_FETCH)
        begin
            rdata_reg <= mem_rdata;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {free_reg, fill_reg, wake_reg, rdata_reg, granted_reg};

    // Checks
    a_fetch_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !mvalid_reg && !s_tready)
        else $error("result shown or request taken during a store read");

    a_fetch_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> mvalid_reg)
        else $error("read byte result not presented after store read");

    a_fill_fits: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg |-> (32'(fill_reg) + 32'(free_reg)) <= 32'(CAPACITY))
        else $error("fill level and free space exceed capacity");

    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && last_reg) |-> (status_reg == ST_OK))
        else $error("end of transfer reported with a failing status");

endmodule

/* verif/message_atomic_byte_ring_buffer_tb.sv */
// Self-checking testbench for the message-atomic byte ring buffer: a shadow of the buffer
// predicts every response, which is checked field by field as the block returns it.
// Depends on mabrb_pkg and message_atomic_byte_ring_buffer.
module message_atomic_byte_ring_buffer_tb;
    import mabrb_pkg::*;

    // Opcodes the block does not define
    localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 175;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_byte;
        logic              nonblocking;
        logic              peers;
        logic [SIZE_W-1:0] lead;
    } buf_op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] granted;
        logic [BYTE_W-1:0] rdata;
        logic              done;
        logic              wake;
        logic [SIZE_W-1:0] fill;
        logic [SIZE_W-1:0] room;
    } buf_resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SIZE_W-1:0]  cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OPC_W-1:0]   s_tuser = '0;
    logic [IN_DW-1:0]   s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [STAT_W-1:0]  m_tuser;
    logic               m_tlast;
    logic [OUT_DW-1:0]  m_tdata;

    // Shadow of the buffer
    logic [BYTE_W-1:0]  ring_mem [0:CAPACITY_DEF-1];
    int unsigned        ring_rd = 0;
    int unsigned        ring_wr = 0;
    int unsigned        ring_fill = 0;
    int unsigned        ring_left = 0;
    int unsigned        ring_total = 0;
    logic [DIR_W-1:0]   ring_dir = DIR_NONE;
    logic [SIZE_W-1:0]  ring_size_reg = SIZE_W'(BUF_SIZE_RST);

    buf_op_t            pending_ops [$];
    buf_resp_t          awaited_resps [$];
    buf_op_t            on_bus;
    buf_resp_t          last_resp;
    int unsigned        ops_offered = 0;
    int unsigned        ops_taken = 0;
    int unsigned        resps_seen = 0;
    int unsigned        fail_count = 0;
    int unsigned        burst_left = 0;
    int unsigned        gap_left = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        hold_left = 0;
    int unsigned        stall_tick = 0;
    logic [15:0]        ready_pattern = 16'hFFFF;

    message_atomic_byte_ring_buffer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Size in use: register clamped to 1..capacity
    function automatic int unsigned ring_span();
        if (ring_size_reg == '0)
            return 1;
        if (int'(ring_size_reg) > CAPACITY_DEF)
            return CAPACITY_DEF;
        return int'(ring_size_reg);
    endfunction

    function automatic void ring_clear();
        ring_rd = 0;
        ring_wr = 0;
        ring_fill = 0;
        ring_left = 0;
        ring_total = 0;
        ring_dir = DIR_NONE;
    endfunction

    // Response of the buffer to one transaction; updates the shadow
    function automatic buf_resp_t buffer_response(input buf_op_t op);
        buf_resp_t   r;
        int unsigned span;
        int unsigned want;
        span = ring_span();
        r = '0;
        want = int'(op.length);
        case (op.opcode)
            OP_WR_REQ:
            begin
                if (ring_dir != DIR_NONE)
                    r.status = ST_SEQ;
                else if (want == 0)
                    r.status = ST_OK;
                else if (want > span)
                    r.status = ST_INVALID;
                else if (ring_fill + want > span)
                begin
                    if (op.nonblocking)
                        r.status = ST_WOULDBLOCK;
                    else
                    begin
                        r.status = ST_WAIT;
                        r.wake = (ring_fill > 0) && op.peers;
                    end
                end
                else
                begin
                    r.granted = SIZE_W'(want);
                    ring_dir = DIR_WRITE;
                    ring_total = want;
                    ring_left = want;
                end
            end
            OP_WR_BYTE:
            begin
                if (ring_dir != DIR_WRITE || ring_left == 0 || ring_fill >= span)
                    r.status = ST_SEQ;
                else
                begin
                    ring_mem[ring_wr] = op.data_byte;
                    ring_wr = (ring_wr + 1 >= span) ? 0 : ring_wr + 1;
                    ring_fill++;
                    ring_left--;
                    r.granted = SIZE_W'(ring_total);
                    if (ring_left == 0)
                    begin
                        r.done = 1'b1;
                        r.wake = op.peers && (int'(op.lead) <= ring_fill);
                        ring_dir = DIR_NONE;
                        ring_total = 0;
                    end
                end
            end
            OP_RD_REQ:
            begin
                if (ring_dir != DIR_NONE)
                    r.status = ST_SEQ;
                else if (want == 0)
                    r.status = ST_OK;
                else if (want > span)
                    r.status = ST_INVALID;
                else
                begin
                    // short read of the whole fill when writers are queued
                    if (ring_fill < want)
                    begin
                        if (op.nonblocking)
                            r.status = ST_WOULDBLOCK;
                        else if (ring_fill > 0 && op.peers)
                            want = ring_fill;
                        else
                            r.status = ST_WAIT;
                    end
                    if (r.status == ST_OK)
                    begin
                        r.granted = SIZE_W'(want);
                        ring_dir = DIR_READ;
                        ring_total = want;
                        ring_left = want;
                    end
                end
            end
            OP_RD_BYTE:
            begin
                if (ring_dir != DIR_READ || ring_left == 0 || ring_fill == 0)
                    r.status = ST_SEQ;
                else
                begin
                    r.rdata = ring_mem[ring_rd];
                    ring_rd = (ring_rd + 1 >= span) ? 0 : ring_rd + 1;
                    ring_fill--;
                    ring_left--;
                    r.granted = SIZE_W'(ring_total);
                    if (ring_left == 0)
                    begin
                        r.done = 1'b1;
                        r.wake = op.peers && (int'(op.lead) + ring_fill <= span);
                        ring_dir = DIR_NONE;
                        ring_total = 0;
                    end
                end
            end
            OP_CLEAR:
            begin
                ring_clear();
                r.wake = op.peers;
            end
            OP_INQUIRE:
            begin
                r.status = ST_OK;
            end
            default:
            begin
                r.status = ST_SEQ;
            end
        endcase
        r.fill = SIZE_W'(ring_fill);
        r.room = SIZE_W'(span - ring_fill);
        return r;
    endfunction

    function automatic buf_op_t make_op(input logic [OPC_W-1:0] opc, input int unsigned len,
                                        input int unsigned data, input bit nb, input bit peers,
                                        input int unsigned lead);
        buf_op_t op;
        op.opcode = opc;
        op.length = LEN_W'(len);
        op.data_byte = BYTE_W'(data);
        op.nonblocking = nb;
        op.peers = peers;
        op.lead = SIZE_W'(lead);
        return op;
    endfunction

    // Random fields; the waiter size mostly lands near the current size
    function automatic buf_op_t random_op(input logic [OPC_W-1:0] opc);
        int unsigned span;
        int unsigned lead;
        span = ring_span();
        if ($urandom_range(0, 3) == 0)
            lead = $urandom_range(0, 8191);
        else
            lead = $urandom_range(0, span + 2);
        return make_op(opc, $urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0, lead);
    endfunction

    // Message length: mostly short, some oversize, zero and wild values
    function automatic logic [LEN_W-1:0] msg_length();
        int unsigned span;
        int unsigned cap;
        span = ring_span();
        cap = (span > 256) ? 256 : span;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return LEN_W'(span + $urandom_range(1, 8));
            2: return LEN_W'($urandom_range(span + 1, 65535));
            3: return LEN_W'($urandom_range(1, cap));
            default: return LEN_W'($urandom_range(1, (cap < 12) ? cap : 12));
        endcase
    endfunction

    task automatic post(input buf_op_t op);
        pending_ops.push_back(op);
        ops_offered++;
    endtask

    // Wait until every posted transaction has been taken
    task automatic settle();
        while (ops_taken != ops_offered)
            @(negedge clk);
    endtask

    task automatic drain_buffer();
        while (pending_ops.size() != 0 || s_tvalid || awaited_resps.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_size(input int unsigned value);
        drain_buffer();
        @(posedge clk);
        cfg_data <= SIZE_W'(value);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        ring_size_reg = SIZE_W'(value);
        ring_clear();
        @(negedge clk);
    endtask

    // Finish or abort whatever transfer the shadow shows as open
    task automatic close_transfer();
        int unsigned left;
        left = ring_left;
        if (ring_dir == DIR_NONE)
            return;
        if ($urandom_range(0, 1) == 0)
            post(random_op(OP_CLEAR));
        else
            for (int i = 0; i < left; i++)
                post(random_op((ring_dir == DIR_WRITE) ? OP_WR_BYTE : OP_RD_BYTE));
    endtask

    task automatic run_message(input bit is_read);
        buf_op_t     op;
        int unsigned granted;
        int unsigned sent;
        op = random_op(is_read ? OP_RD_REQ : OP_WR_REQ);
        op.length = msg_length();
        post(op);
        settle();
        granted = (last_resp.status == ST_OK) ? int'(last_resp.granted) : 0;
        if (granted == 0)
            return;
        sent = ($urandom_range(0, 19) == 0) ? $urandom_range(0, granted - 1) : granted;
        for (int i = 0; i < sent; i++)
            post(random_op(is_read ? OP_RD_BYTE : OP_WR_BYTE));
        if (sent < granted)
        begin
            // broken message: a request and a wrong-way byte while it is still open
            post(random_op(($urandom_range(0, 1) != 0) ? OP_WR_REQ : OP_RD_REQ));
            post(random_op(is_read ? OP_WR_BYTE : OP_RD_BYTE));
            settle();
            close_transfer();
        end
    endtask

    // Stimulus
    initial
    begin
        int unsigned phase_sizes [9];
        int unsigned phase_end;
        int unsigned pick;
        phase_sizes = '{16, 13, 1, 0, 8191, 37, 4096, 5, 2};
        phase_sizes[8] = $urandom_range(2, 64);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty buffer, rejects, short read, sequence errors
        post(make_op(OP_INQUIRE, 0, 0, 1, 1, 8191));
        post(make_op(OP_RD_BYTE, 0, 0, 0, 1, 0));
        post(make_op(OP_WR_BYTE, 0, 255, 0, 1, 0));
        post(make_op(OP_WR_REQ, 0, 0, 0, 0, 0));
        post(make_op(OP_WR_REQ, 65535, 255, 1, 1, 8191));
        post(make_op(OP_RD_REQ, 4097, 0, 0, 1, 0));
        post(make_op(OP_RD_REQ, 5, 0, 1, 1, 0));
        post(make_op(OP_RD_REQ, 5, 0, 0, 1, 0));
        post(make_op(OP_WR_REQ, 3, 0, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'h00, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'hFF, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'hA5, 0, 1, 3));
        post(make_op(OP_WR_REQ, 2, 0, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'h5A, 0, 0, 0));
        post(make_op(OP_RD_REQ, 1, 0, 0, 1, 0));
        post(make_op(OP_RD_BYTE, 0, 0, 0, 0, 0));
        post(make_op(OP_WR_REQ, 1, 0, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'h3C, 0, 1, 8191));
        post(make_op(OP_RD_REQ, 10, 0, 0, 1, 0));
        for (int i = 0; i < 5; i++)
            post(make_op(OP_RD_BYTE, 0, 0, 0, i == 4, 4091));
        post(make_op(OP_CLEAR, 0, 0, 0, 1, 0));
        post(make_op(OP_SPARE_6, 0, 0, 0, 0, 0));
        post(make_op(OP_SPARE_7, 0, 0, 0, 0, 0));
        // leave a write open so the size change has to abort it
        post(make_op(OP_WR_REQ, 6, 0, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'h81, 0, 0, 0));
        post(make_op(OP_WR_BYTE, 0, 8'h7E, 0, 0, 0));

        // Random phases over a range of sizes, extremes included
        for (int p = 0; p < 9; p++)
        begin
            set_size(phase_sizes[p]);
            phase_end = ops_offered + PHASE_ITEMS;
            while (ops_offered < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    run_message(1'b0);
                else if (pick < 84)
                    run_message(1'b1);
                else if (pick < 89)
                    post(random_op(OP_CLEAR));
                else if (pick < 93)
                    post(random_op(OP_INQUIRE));
                else if (pick < 99)
                begin
                    post(random_op(OPC_W'($urandom_range(0, 7))));
                    settle();
                    close_transfer();
                end
                else
                    drain_buffer();
            end
        end

        drain_buffer();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Driver: bursts of transactions with random gaps; predicts each one taken
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                last_resp = buffer_response(on_bus);
                awaited_resps.push_back(last_resp);
                ops_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    on_bus = pending_ops.pop_front();
                    s_tuser <= on_bus.opcode;
                    s_tdata <= {1'b0, on_bus.lead, on_bus.peers, on_bus.nonblocking,
                                on_bus.data_byte, on_bus.length};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response, stalls on its own pattern and holds off twice
    always @(posedge clk)
    begin
        buf_resp_t got;
        buf_resp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.granted = m_tdata[12:0];
                got.rdata = m_tdata[20:13];
                got.done = m_tlast;
                got.wake = m_tdata[21];
                got.fill = m_tdata[34:22];
                got.room = m_tdata[47:35];
                if (awaited_resps.size() == 0)
                begin
                    $error("response with no transaction awaiting it");
                    fail_count++;
                end
                else
                begin
                    want = awaited_resps.pop_front();
                    if (got.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    if (got.granted !== want.granted)
                        $error("granted_length: expected %0d, got %0d", want.granted,
                               got.granted);
                    if (got.rdata !== want.rdata)
                        $error("read_data: expected %0d, got %0d", want.rdata, got.rdata);
                    if (got.done !== want.done)
                        $error("transfer_done: expected %0d, got %0d", want.done, got.done);
                    if (got.wake !== want.wake)
                        $error("wake_peers: expected %0d, got %0d", want.wake, got.wake);
                    if (got.fill !== want.fill)
                        $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
                    if (got.room !== want.room)
                        $error("free_space: expected %0d, got %0d", want.room, got.room);
                    if (got !== want)
                        fail_count++;
                end
                resps_seen++;
                if (resps_seen == 400 || resps_seen == 1000)
                    hold_left = HOLD_CYCLES;
            end
            // stall pattern redrawn periodically, sometimes none at all
            stall_tick++;
            if (stall_tick % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom | $urandom);
                    2: ready_pattern = 16'($urandom) | 16'h8000;
                    default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ready_pattern[stall_tick % 16];
        end
    end

    // Watchdog: too long with work outstanding and no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_ops.size() == 0 && !s_tvalid && awaited_resps.size() == 0))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
